FILE: rtl/core/psma_pkg.sv
package psma_pkg;

    localparam int SAMPLE_W = 25;
    localparam int NUM_W    = 47;
    localparam int P_QW     = 24;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [NUM_W-1:0]    t_num;
    typedef logic [1:0]                 t_status;

    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_ZERO_SUPPLY = 2'd1;
    localparam t_status ST_CLIPPED     = 2'd2;

    localparam t_num K_P_GAIN   = 47'sd2468000;
    localparam t_num K_P_OFFSET = 47'sd98720;

    localparam logic signed [25:0] K_T_OFFSET = 26'sd273150;
    localparam logic signed [25:0] T_LOW      = -26'sd10273150;
    localparam logic signed [25:0] T_HIGH     = 26'sd9726850;

    localparam t_sample          P_FULL     = 25'sd10000000;
    localparam t_sample          P_FULL_NEG = -25'sd10000000;
    localparam logic [P_QW-1:0]  P_FULL_MAG = 24'd10000000;

    typedef struct packed {
        logic rd;
        logic wr;
        logic drop;
    } t_ring_ctl;

endpackage

FILE: rtl/core/pt_sensor_moving_average.sv
// Pressure/temperature sensor conversion with a boxcar moving average.
// Input channel (i_in_valid / o_in_stall) carries one transaction of three
// signed microvolt samples: supply, temperature sensor, pressure sensor.
// Output channel (o_out_valid / i_out_stall) returns one transaction per
// input: mean temperature (milli-degrees C), mean pressure (thousandths of
// a millibar) and a status code (ok, zero supply, pressure clipped).
// One transaction is processed at a time: the block takes no new input
// until the result of the last one is in the output register. Processing
// runs through bit-serial dividers, one quotient bit per cycle: 24 bits
// for the pressure ratio, then SUMW bits for both means in parallel, where
// SUMW = 25 + clog2(WINDOW_DEPTH).
// Reset empties the window: the first means cover only the samples seen
// so far, until WINDOW_DEPTH samples have arrived.
// A finished result waits in the output register while i_out_stall is high;
// the next input is accepted and processed meanwhile, and its result is
// held in the last step until the output register is free.
module pt_sensor_moving_average #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  psma_pkg::t_sample  i_supply_uv,
    input  psma_pkg::t_sample  i_temp_sense_uv,
    input  psma_pkg::t_sample  i_pressure_sense_uv,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output psma_pkg::t_sample  o_avg_temp_mc,
    output psma_pkg::t_sample  o_avg_pressure_mmbar,
    output psma_pkg::t_status  o_status
);
    import psma_pkg::*;

    localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUMW = SAMPLE_W + $clog2(WINDOW_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_ABS,
        S_PSTART,
        S_PDIV,
        S_RWR,
        S_MSTART,
        S_MDIV,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_sample r_avg_temp;
    t_sample r_avg_pres;
    t_status r_status;
    logic [AW-1:0] r_slot;
    logic [CW-1:0] r_fill;

    t_sample        r_s;
    t_sample        r_pv;
    t_sample        r_t;
    t_num           r_pa;
    t_num           r_pb;
    t_num           r_num;
    logic [NUM_W-2:0]    r_num_mag;
    logic [SAMPLE_W-1:0] r_s_mag;
    logic           r_p_neg;
    logic           r_povf;
    t_sample        r_p;
    t_status        r_pstat;
    logic           r_tneg;
    logic           r_pmneg;

    logic signed [25:0] w_tdiff;
    t_sample            w_tclamp;
    logic               w_pdone;
    logic [P_QW-1:0]    w_pquo;
    logic               w_pclip;
    logic [P_QW-1:0]    w_pmag;
    logic [SAMPLE_W-1:0] w_pmag_x;
    t_sample            w_pval;
    logic               w_szero;
    logic               w_load;

    t_ring_ctl              w_ring_ctl;
    logic signed [SUMW-1:0] w_tsum;
    logic signed [SUMW-1:0] w_psum;
    logic [SUMW-1:0]        w_tsum_mag;
    logic [SUMW-1:0]        w_psum_mag;
    logic                   w_tdone;
    logic                   w_pmdone;
    logic [SUMW-1:0]        w_tquo;
    logic [SUMW-1:0]        w_pmquo;

    assign w_tdiff  = 26'(i_temp_sense_uv) - K_T_OFFSET;
    assign w_tclamp = (w_tdiff < T_LOW)  ? t_sample'(T_LOW)  :
                      (w_tdiff > T_HIGH) ? t_sample'(T_HIGH) : t_sample'(w_tdiff);

    psma_sdiv #(
        .QW (P_QW),
        .DW (SAMPLE_W)
    ) u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PSTART),
        .i_hi    ({3'b000, r_num_mag[NUM_W-2:P_QW]}),
        .i_lo    (r_num_mag[P_QW-1:0]),
        .i_den   (r_s_mag),
        .o_done  (w_pdone),
        .o_quo   (w_pquo)
    );

    assign w_szero  = (r_s == '0);
    assign w_pclip  = r_povf || (w_pquo > P_FULL_MAG);
    assign w_pmag   = w_pclip ? P_FULL_MAG : w_pquo;
    assign w_pmag_x = {1'b0, w_pmag};
    assign w_pval   = r_p_neg ? t_sample'(~w_pmag_x + 25'd1) : t_sample'(w_pmag_x);

    assign w_ring_ctl.rd   = (r_state == S_ABS);
    assign w_ring_ctl.wr   = (r_state == S_RWR);
    assign w_ring_ctl.drop = (r_fill == CW'(WINDOW_DEPTH));

    psma_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW),
        .SUMW  (SUMW)
    ) u_tring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ring_ctl),
        .i_slot  (r_slot),
        .i_data  (r_t),
        .o_sum   (w_tsum)
    );

    psma_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW),
        .SUMW  (SUMW)
    ) u_pring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ring_ctl),
        .i_slot  (r_slot),
        .i_data  (r_p),
        .o_sum   (w_psum)
    );

    assign w_tsum_mag = w_tsum[SUMW-1] ? SUMW'(-w_tsum) : SUMW'(w_tsum);
    assign w_psum_mag = w_psum[SUMW-1] ? SUMW'(-w_psum) : SUMW'(w_psum);

    psma_sdiv #(
        .QW (SUMW),
        .DW (CW)
    ) u_tmdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MSTART),
        .i_hi    ('0),
        .i_lo    (w_tsum_mag),
        .i_den   (r_fill),
        .o_done  (w_tdone),
        .o_quo   (w_tquo)
    );

    psma_sdiv #(
        .QW (SUMW),
        .DW (CW)
    ) u_pmdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MSTART),
        .i_hi    ('0),
        .i_lo    (w_psum_mag),
        .i_den   (r_fill),
        .o_done  (w_pmdone),
        .o_quo   (w_pmquo)
    );

    assign w_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MUL;
            S_MUL:    n_state = S_ADD;
            S_ADD:    n_state = S_ABS;
            S_ABS:    n_state = S_PSTART;
            S_PSTART: n_state = S_PDIV;
            S_PDIV:   if (w_pdone) n_state = S_RWR;
            S_RWR:    n_state = S_MSTART;
            S_MSTART: n_state = S_MDIV;
            S_MDIV:   if (w_tdone && w_pmdone) n_state = S_DONE;
            S_DONE:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_slot      <= '0;
            r_fill      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RWR) begin
                if (!w_ring_ctl.drop) begin
                    r_fill <= r_fill + CW'(1);
                end
                r_slot <= (r_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : r_slot + AW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_avg_temp  <= r_tneg  ? t_sample'(~w_tquo[SAMPLE_W-1:0] + 25'd1)
                                       : t_sample'(w_tquo[SAMPLE_W-1:0]);
                r_avg_pres  <= r_pmneg ? t_sample'(~w_pmquo[SAMPLE_W-1:0] + 25'd1)
                                       : t_sample'(w_pmquo[SAMPLE_W-1:0]);
                r_status    <= r_pstat;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_s  <= i_supply_uv;
            r_pv <= i_pressure_sense_uv;
            r_t  <= w_tclamp;
        end
        if (r_state == S_MUL) begin
            r_pa <= t_num'(r_pv) * K_P_GAIN;
            r_pb <= t_num'(r_s) * K_P_OFFSET;
        end
        if (r_state == S_ADD) begin
            r_num <= r_pa + r_pb;
        end
        if (r_state == S_ABS) begin
            r_num_mag <= r_num[NUM_W-1] ? (NUM_W-1)'(-r_num) : (NUM_W-1)'(r_num);
            r_s_mag   <= r_s[SAMPLE_W-1] ? SAMPLE_W'(-r_s) : SAMPLE_W'(r_s);
            r_p_neg   <= r_num[NUM_W-1] ^ r_s[SAMPLE_W-1];
        end
        if (r_state == S_PSTART) begin
            r_povf <= ({3'b000, r_num_mag[NUM_W-2:P_QW]} >= r_s_mag);
        end
        if (r_state == S_PDIV && w_pdone) begin
            r_p     <= w_szero ? P_FULL : w_pval;
            r_pstat <= w_szero ? ST_ZERO_SUPPLY : (w_pclip ? ST_CLIPPED : ST_OK);
        end
        if (r_state == S_MSTART) begin
            r_tneg  <= w_tsum[SUMW-1];
            r_pmneg <= w_psum[SUMW-1];
        end
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_avg_temp_mc        = r_avg_temp;
    assign o_avg_pressure_mmbar = r_avg_pres;
    assign o_status             = r_status;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_warmup_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != CW'(WINDOW_DEPTH)) |-> (r_slot == AW'(r_fill)))
        else $error("write slot out of step with fill count during warm-up");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_ZERO_SUPPLY ||
                         o_status == ST_CLIPPED))
        else $error("invalid status code on output");

    a_pres_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_avg_pressure_mmbar <= P_FULL &&
                         o_avg_pressure_mmbar >= P_FULL_NEG))
        else $error("mean pressure outside full scale");

endmodule

FILE: rtl/core/psma_sdiv.sv
module psma_sdiv #(
    parameter int QW = 24,
    parameter int DW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_hi,
    input  logic [QW-1:0] i_lo,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);
    localparam int CNTW = $clog2(QW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [QW-1:0]   r_sh;
    logic [DW-1:0]   r_den;

    logic [DW:0]     w_trial;
    logic [DW+1:0]   w_diff;
    logic            w_ge;
    logic [DW-1:0]   n_rem;

    assign w_trial = {r_rem, r_sh[QW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign w_ge    = !w_diff[DW+1];
    assign n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_hi;
            r_sh  <= i_lo;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_sh;

endmodule

FILE: rtl/core/psma_ring.sv
module psma_ring #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int SUMW  = 28
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  psma_pkg::t_ring_ctl      i_ctl,
    input  logic [AW-1:0]            i_slot,
    input  psma_pkg::t_sample        i_data,
    output logic signed [SUMW-1:0]   o_sum
);
    import psma_pkg::*;

    t_sample                r_mem [DEPTH];
    t_sample                r_old;
    logic signed [SUMW-1:0] r_sum;
    logic signed [SUMW-1:0] w_drop_val;
    logic signed [SUMW-1:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_old <= r_mem[i_slot];
        end
        if (i_ctl.wr) begin
            r_mem[i_slot] <= i_data;
        end
    end

    assign w_drop_val = i_ctl.drop ? SUMW'(r_old) : '0;
    assign n_sum      = r_sum - w_drop_val + SUMW'(i_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.wr) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

FILE: sim/pt_sensor_moving_average_tb.sv
module pt_sensor_moving_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psma_pkg::*;

    localparam int WINDOW       = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int LONG_HOLD    = 600;

    typedef struct {
        t_sample temp;
        t_sample pressure;
        t_status status;
    } t_mean_result;

    logic    i_clk               = 1'b0;
    logic    i_rst_n             = 1'b0;
    logic    in_valid            = 1'b0;
    logic    out_stall           = 1'b0;
    t_sample supply_uv           = '0;
    t_sample temp_sense_uv       = '0;
    t_sample pressure_sense_uv   = '0;
    logic    o_in_stall;
    logic    o_out_valid;
    t_sample o_avg_temp_mc;
    t_sample o_avg_pressure_mmbar;
    t_status o_status;

    t_mean_result expected_means[$];
    int  errors    = 0;
    bit  calm      = 1'b0;
    int  hold_req  = 0;

    longint temp_hist[WINDOW];
    longint pres_hist[WINDOW];
    int     hist_slot   = 0;
    int     hist_filled = 0;
    longint temp_total  = 0;
    longint pres_total  = 0;

    pt_sensor_moving_average #(
        .WINDOW_DEPTH(WINDOW)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (o_in_stall),
        .i_supply_uv         (supply_uv),
        .i_temp_sense_uv     (temp_sense_uv),
        .i_pressure_sense_uv (pressure_sense_uv),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (out_stall),
        .o_avg_temp_mc       (o_avg_temp_mc),
        .o_avg_pressure_mmbar(o_avg_pressure_mmbar),
        .o_status            (o_status)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("pt_sensor_moving_average_tb failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic void predict_means(t_sample supply, t_sample temp_uv, t_sample pres_uv);
        longint       s;
        longint       t_new;
        longint       p_new;
        longint       num;
        longint       mean;
        t_mean_result r;
        s = supply;
        r.status = ST_OK;
        t_new = longint'(temp_uv) - longint'(K_T_OFFSET);
        if (t_new < longint'(T_LOW)) t_new = T_LOW;
        if (t_new > longint'(T_HIGH)) t_new = T_HIGH;
        if (s == 0) begin
            p_new = P_FULL;
            r.status = ST_ZERO_SUPPLY;
        end else begin
            num = longint'(K_P_GAIN) * longint'(pres_uv) + longint'(K_P_OFFSET) * s;
            p_new = num / s;
            if (p_new > longint'(P_FULL)) begin
                p_new = P_FULL;
                r.status = ST_CLIPPED;
            end else if (p_new < longint'(P_FULL_NEG)) begin
                p_new = P_FULL_NEG;
                r.status = ST_CLIPPED;
            end
        end
        if (hist_filled >= WINDOW) begin
            temp_total -= temp_hist[hist_slot];
            pres_total -= pres_hist[hist_slot];
        end else begin
            hist_filled++;
        end
        temp_hist[hist_slot] = t_new;
        pres_hist[hist_slot] = p_new;
        temp_total += t_new;
        pres_total += p_new;
        hist_slot = (hist_slot + 1) % WINDOW;
        mean = temp_total / hist_filled;
        r.temp = mean[SAMPLE_W-1:0];
        mean = pres_total / hist_filled;
        r.pressure = mean[SAMPLE_W-1:0];
        expected_means.push_back(r);
    endfunction

    task automatic send_sample(input t_sample supply, input t_sample temp_uv,
                               input t_sample pres_uv);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid          <= 1'b1;
        supply_uv         <= supply;
        temp_sense_uv     <= temp_uv;
        pressure_sense_uv <= pres_uv;
        do @(posedge i_clk); while (o_in_stall);
        predict_means(supply, temp_uv, pres_uv);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_sensor_sample();
        int s;
        int t;
        int p;
        s = $urandom_range(4500000, 5500000);
        t = $urandom_range(173150, 423150);
        if ($urandom_range(0, 9) != 0) p = $urandom_range(0, s);
        else p = $urandom_range(s, 16000000);
        send_sample(t_sample'(s), t_sample'(t), t_sample'(p));
    endtask

    task automatic test_warmup_and_extremes();
        send_sample(25'sd5000000, 25'sd298150, 25'sd2500000);
        send_sample(25'sd5000000, 25'sd273150, 25'sd0);
        send_sample(25'sd0, 25'sd0, 25'sd0);
        send_sample(25'sd0, 25'sd16777215, -25'sd16777216);
        send_sample(25'sd5000000, -25'sd16777216, 25'sd1000000);
        send_sample(25'sd5000000, 25'sd10000000, 25'sd5000000);
        send_sample(25'sd5000000, -25'sd10000000, -25'sd5000000);
        send_sample(25'sd1, 25'sd0, 25'sd1);
        send_sample(25'sd1, 25'sd0, 25'sd10);
        send_sample(-25'sd1, 25'sd0, 25'sd10);
        send_sample(25'sd16777215, 25'sd0, 25'sd16777215);
        send_sample(-25'sd16777216, 25'sd0, 25'sd16777215);
        send_sample(-25'sd16777216, 25'sd0, -25'sd16777216);
        send_sample(25'sd16777215, 25'sd0, -25'sd16777216);
        send_sample(25'sd3, 25'sd0, -25'sd16777216);
        send_sample(-25'sd5000000, 25'sd300000, -25'sd2500000);
        send_sample(25'sd2468000, 25'sd0, 25'sd9901280);
        send_sample(25'sd2468000, 25'sd0, 25'sd9901281);
        send_sample(25'sd2468000, 25'sd0, -25'sd10098720);
        send_sample(25'sd2468000, 25'sd0, -25'sd10098721);
        send_sample(25'sd5000000, 25'sd16777215, 25'sd16000000);
    endtask

    task automatic test_sensor_sweep(input int count);
        repeat (count) send_sensor_sample();
    endtask

    task automatic test_wide_noise(input int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                send_sample('0, t_sample'($urandom), t_sample'($urandom));
            else if (r == 1)
                send_sample(t_sample'($urandom_range(0, 128)) - 25'sd64,
                            t_sample'($urandom), t_sample'($urandom));
            else
                send_sample(t_sample'($urandom), t_sample'($urandom), t_sample'($urandom));
        end
    endtask

    task automatic test_output_hold();
        calm = 1'b1;
        hold_req = LONG_HOLD;
        repeat (12) send_sensor_sample();
        calm = 1'b0;
    endtask

    task automatic test_drain_pause();
        test_sensor_sweep(20);
        wait_drained();
        calm = 1'b1;
        test_sensor_sweep(60);
        calm = 1'b0;
        test_sensor_sweep(20);
    endtask

    initial begin
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (run_left > 0) begin
                    run_left--;
                end else if (!calm) begin
                    run_left   = $urandom_range(0, 12);
                    stall_left = idle_len();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_mean_result want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_means.size() == 0) begin
                $error("result transaction with no expectation pending");
                errors++;
            end else begin
                want = expected_means.pop_front();
                if (o_avg_temp_mc !== want.temp) begin
                    $error("avg_temp_mc: expected %0d, actual %0d", want.temp, o_avg_temp_mc);
                    errors++;
                end
                if (o_avg_pressure_mmbar !== want.pressure) begin
                    $error("avg_pressure_mmbar: expected %0d, actual %0d",
                           want.pressure, o_avg_pressure_mmbar);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_warmup_and_extremes();
        test_sensor_sweep(300);
        test_output_hold();
        test_wide_noise(150);
        test_drain_pause();
        test_sensor_sweep(170);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("pt_sensor_moving_average_tb passed");
        end else begin
            $display("pt_sensor_moving_average_tb failed");
        end
        $finish;
    end

endmodule

FILE: pt_sensor_moving_average.f
rtl/core/psma_pkg.sv
rtl/core/psma_sdiv.sv
rtl/core/psma_ring.sv
rtl/core/pt_sensor_moving_average.sv
sim/pt_sensor_moving_average_tb.sv
